// File: design/z80alu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package z80alu_pkg;

  typedef enum logic [4:0] {
    CMD_ADD8  = 5'd0,
    CMD_ADC8  = 5'd1,
    CMD_SUB8  = 5'd2,
    CMD_SBC8  = 5'd3,
    CMD_AND   = 5'd4,
    CMD_XOR   = 5'd5,
    CMD_OR    = 5'd6,
    CMD_INC   = 5'd7,
    CMD_DEC   = 5'd8,
    CMD_RLC   = 5'd9,
    CMD_RRC   = 5'd10,
    CMD_RL    = 5'd11,
    CMD_RR    = 5'd12,
    CMD_SLA   = 5'd13,
    CMD_SRA   = 5'd14,
    CMD_SLL   = 5'd15,
    CMD_SRL   = 5'd16,
    CMD_ADD16 = 5'd17,
    CMD_ADC16 = 5'd18,
    CMD_SBC16 = 5'd19,
    CMD_IN    = 5'd20,
    CMD_LDF   = 5'd21
  } cmd_e;

  typedef struct packed {
    logic s;
    logic z;
    logic h;
    logic pv;
    logic n;
    logic c;
  } flag_t;

  // S7 Z6 H4 PV2 N1 C0, bits 5 and 3 read as zero
  function automatic logic [7:0] pack_flags(flag_t f);
    return {f.s, f.z, 1'b0, f.h, 1'b0, f.pv, f.n, f.c};
  endfunction

  function automatic flag_t unpack_flags(logic [7:0] v);
    flag_t f;
    f.s  = v[7];
    f.z  = v[6];
    f.h  = v[4];
    f.pv = v[2];
    f.n  = v[1];
    f.c  = v[0];
    return f;
  endfunction

endpackage

`default_nettype wire

// File: design/z80alu_core.sv
`timescale 1ns / 1ps
`default_nettype none

module z80alu_core import z80alu_pkg::*; (
  input  logic [4:0]  cmd_i,
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  input  flag_t       flags_i,
  output logic [15:0] result_o,
  output flag_t       flags_o
);

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic        cin8;
  logic        cin16;
  logic [8:0]  add9;
  logic [8:0]  sub9;
  logic [4:0]  addh5;
  logic [4:0]  subh5;
  logic [16:0] add17;
  logic [16:0] sub17;
  logic [12:0] addh13;
  logic [12:0] subh13;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [7:0]  sh8;
  logic        sh_out;
  logic [7:0]  r8;

  assign a8 = a_i[7:0];
  assign b8 = b_i[7:0];
  assign cin8  = ((cmd_i == CMD_ADC8) || (cmd_i == CMD_SBC8)) ? flags_i.c : 1'b0;
  assign cin16 = (cmd_i == CMD_ADD16) ? 1'b0 : flags_i.c;

  assign add9   = {1'b0, a8} + {1'b0, b8} + {8'd0, cin8};
  assign sub9   = {1'b0, a8} - {1'b0, b8} - {8'd0, cin8};
  assign addh5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin8};
  assign subh5  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin8};
  assign add17  = {1'b0, a_i} + {1'b0, b_i} + {16'd0, cin16};
  assign sub17  = {1'b0, a_i} - {1'b0, b_i} - {16'd0, cin16};
  assign addh13 = {1'b0, a_i[11:0]} + {1'b0, b_i[11:0]} + {12'd0, cin16};
  assign subh13 = {1'b0, a_i[11:0]} - {1'b0, b_i[11:0]} - {12'd0, cin16};
  assign inc8   = a8 + 8'd1;
  assign dec8   = a8 - 8'd1;

  // rotate and shift group
  always_comb begin
    sh8    = a8;
    sh_out = 1'b0;
    case (cmd_i)
      CMD_RLC: begin sh8 = {a8[6:0], a8[7]};      sh_out = a8[7]; end
      CMD_RRC: begin sh8 = {a8[0], a8[7:1]};      sh_out = a8[0]; end
      CMD_RL:  begin sh8 = {a8[6:0], flags_i.c};  sh_out = a8[7]; end
      CMD_RR:  begin sh8 = {flags_i.c, a8[7:1]};  sh_out = a8[0]; end
      CMD_SLA: begin sh8 = {a8[6:0], 1'b0};       sh_out = a8[7]; end
      CMD_SRA: begin sh8 = {a8[7], a8[7:1]};      sh_out = a8[0]; end
      CMD_SLL: begin sh8 = {a8[6:0], 1'b1};       sh_out = a8[7]; end
      CMD_SRL: begin sh8 = {1'b0, a8[7:1]};       sh_out = a8[0]; end
      default: begin sh8 = a8;                    sh_out = 1'b0;  end
    endcase
  end

  always_comb begin
    r8       = 8'd0;
    result_o = 16'd0;
    flags_o  = flags_i;
    case (cmd_i)
      CMD_ADD8, CMD_ADC8: begin
        r8 = add9[7:0];
        flags_o.s  = r8[7];
        flags_o.z  = (r8 == 8'd0);
        flags_o.h  = addh5[4];
        flags_o.pv = ~(a8[7] ^ b8[7]) & (a8[7] ^ r8[7]);
        flags_o.n  = 1'b0;
        flags_o.c  = add9[8];
        result_o   = {8'd0, r8};
      end
      CMD_SUB8, CMD_SBC8: begin
        r8 = sub9[7:0];
        flags_o.s  = r8[7];
        flags_o.z  = (r8 == 8'd0);
        flags_o.h  = subh5[4];
        flags_o.pv = (a8[7] ^ b8[7]) & (a8[7] ^ r8[7]);
        flags_o.n  = 1'b1;
        flags_o.c  = sub9[8];
        result_o   = {8'd0, r8};
      end
      CMD_AND, CMD_XOR, CMD_OR: begin
        if (cmd_i == CMD_AND) begin
          r8 = a8 & b8;
        end else if (cmd_i == CMD_XOR) begin
          r8 = a8 ^ b8;
        end else begin
          r8 = a8 | b8;
        end
        flags_o.s  = r8[7];
        flags_o.z  = (r8 == 8'd0);
        flags_o.h  = (cmd_i == CMD_AND);
        flags_o.pv = ~^r8;
        flags_o.n  = 1'b0;
        flags_o.c  = 1'b0;
        result_o   = {8'd0, r8};
      end
      CMD_INC: begin
        r8 = inc8;
        flags_o.s  = r8[7];
        flags_o.z  = (r8 == 8'd0);
        flags_o.h  = (r8[3:0] == 4'h0);
        flags_o.pv = (r8 == 8'h80);
        flags_o.n  = 1'b0;
        result_o   = {8'd0, r8};
      end
      CMD_DEC: begin
        r8 = dec8;
        flags_o.s  = r8[7];
        flags_o.z  = (r8 == 8'd0);
        flags_o.h  = (r8[3:0] == 4'hF);
        flags_o.pv = (r8 == 8'h7F);
        flags_o.n  = 1'b1;
        result_o   = {8'd0, r8};
      end
      CMD_RLC, CMD_RRC, CMD_RL, CMD_RR, CMD_SLA, CMD_SRA, CMD_SLL, CMD_SRL: begin
        r8 = sh8;
        flags_o.s  = r8[7];
        flags_o.z  = (r8 == 8'd0);
        flags_o.h  = 1'b0;
        flags_o.pv = ~^r8;
        flags_o.n  = 1'b0;
        flags_o.c  = sh_out;
        result_o   = {8'd0, r8};
      end
      CMD_ADD16: begin
        // S, Z and PV stay as they were
        flags_o.h = addh13[12];
        flags_o.n = 1'b0;
        flags_o.c = add17[16];
        result_o  = add17[15:0];
      end
      CMD_ADC16: begin
        flags_o.s  = add17[15];
        flags_o.z  = (add17[15:0] == 16'd0);
        flags_o.h  = addh13[12];
        flags_o.pv = ~(a_i[15] ^ b_i[15]) & (a_i[15] ^ add17[15]);
        flags_o.n  = 1'b0;
        flags_o.c  = add17[16];
        result_o   = add17[15:0];
      end
      CMD_SBC16: begin
        flags_o.s  = sub17[15];
        flags_o.z  = (sub17[15:0] == 16'd0);
        flags_o.h  = subh13[12];
        flags_o.pv = (a_i[15] ^ b_i[15]) & (a_i[15] ^ sub17[15]);
        flags_o.n  = 1'b1;
        flags_o.c  = sub17[16];
        result_o   = sub17[15:0];
      end
      CMD_IN: begin
        r8 = a8;
        flags_o.s  = r8[7];
        flags_o.z  = (r8 == 8'd0);
        flags_o.h  = 1'b0;
        flags_o.pv = ~^r8;
        flags_o.n  = 1'b0;
        result_o   = {8'd0, r8};
      end
      CMD_LDF: begin
        flags_o  = unpack_flags(a8);
        result_o = {8'd0, pack_flags(unpack_flags(a8))};
      end
      default: begin
        // unused codes leave the flags alone and return zero
        result_o = 16'd0;
        flags_o  = flags_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/z80_alu_with_flags_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Z80 ALU with its flag register. One command per transaction: the operands are
// captured in an input register, the ALU and flag logic are combinational, and
// the 16-bit result with the packed flag byte (S7 Z6 H4 PV2 N1 C0) lands in an
// output register, so a result passes the input register and then the output
// register. Throughput is one command per cycle while the output is not
// stalled, set by the combinational path from the input register through the
// ALU to the flag register, which supplies carry-in to the next command. The
// flag register updates as each command leaves the input register, so
// back-to-back commands see the flags of their predecessor. Flags reset to zero.
module z80_alu_with_flags_unit import z80alu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  command_i,
  input  logic [15:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] result_o,
  output logic [7:0]  flags_o
);

  logic        s1_valid_q;
  logic [4:0]  s1_cmd_q;
  logic [15:0] s1_a_q;
  logic [15:0] s1_b_q;
  flag_t       flags_q;
  logic        out_valid_q;
  logic [15:0] result_q;
  logic [7:0]  out_flags_q;

  logic        out_free;
  logic        s1_adv;
  logic        in_acc;
  logic [15:0] alu_result;
  flag_t       alu_flags;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  z80alu_core u_core (
    .cmd_i    (s1_cmd_q),
    .a_i      (s1_a_q),
    .b_i      (s1_b_q),
    .flags_i  (flags_q),
    .result_o (alu_result),
    .flags_o  (alu_flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        flags_q <= alu_flags;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q <= command_i;
      s1_a_q   <= operand_a_i;
      s1_b_q   <= operand_b_i;
    end
    if (s1_adv) begin
      result_q    <= alu_result;
      out_flags_q <= pack_flags(alu_flags);
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign flags_o     = out_flags_q;

endmodule

`default_nettype wire

// File: design/z80alu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module z80alu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [4:0]  command_i,
  input logic [15:0] operand_a_i,
  input logic [15:0] operand_b_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] result_o,
  input logic [7:0]  flags_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o) && $stable(flags_o))
    else $error("result changed while stalled");

  // unused flag positions never set
  a_flag_gaps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (flags_o[5] == 1'b0) && (flags_o[3] == 1'b0))
    else $error("flag bit 5 or 3 set");

  // with nothing waiting downstream the block always takes a transaction
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // a result appears only from a transaction accepted earlier into the input register
  a_rise_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without preceding transaction");

endmodule

bind z80_alu_with_flags_unit z80alu_checker u_z80alu_checker (.*);

`default_nettype wire
